// ===== sv/scaa_pkg.sv =====
// ----------------------------------------------------------------------------
// scaa_pkg: shared constants for the subtick calibration averager
// Field widths, configuration register indexes and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package scaa_pkg;

    // Field widths
    localparam int TIME_W  = 16;
    localparam int OFFS_W  = 8;
    localparam int QUOT_W  = 8;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK  = 2'd2;

    // Configuration reset values
    localparam logic [OFFS_W-1:0] BAND_LOW_RST  = 8'd134;
    localparam logic [OFFS_W-1:0] BAND_HIGH_RST = 8'd165;
    localparam logic [OFFS_W-1:0] FALLBACK_RST  = 8'd149;

    typedef logic [OFFS_W-1:0] offs_t;

endpackage

`default_nettype wire

// ===== sv/scaa_ring.sv =====
// ----------------------------------------------------------------------------
// scaa_ring: offset ring storage
// One write port, one registered read port; per-entry valid bits make
// unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module scaa_ring #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 wr_en,
    input  wire [AW-1:0]        wr_addr,
    input  wire scaa_pkg::offs_t wr_data,
    input  wire [AW-1:0]        rd_addr,
    output scaa_pkg::offs_t     rd_data
);

    scaa_pkg::offs_t mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    scaa_pkg::offs_t  rd_data_reg;

    // Mark entries as written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/scaa_divider.sv =====
// ----------------------------------------------------------------------------
// scaa_divider: serial restoring divider
// Produces an 8-bit quotient, one bit per cycle, using a single shared
// compare-and-subtract unit. The quotient is known to fit in 8 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module scaa_divider #(
    parameter int CNT_W = 5,
    parameter int SUM_W = 13
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    input  wire [SUM_W-1:0]             dividend,
    input  wire [CNT_W-1:0]             divisor,
    output logic                        done,
    output logic [scaa_pkg::QUOT_W-1:0] quotient
);

    localparam int STEP_W = $clog2(scaa_pkg::QUOT_W);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic [SUM_W-1:0]            rem_reg, rem_next;
    logic [SUM_W-1:0]            dvs_reg, dvs_next;
    logic [scaa_pkg::QUOT_W-1:0] quot_reg, quot_next;
    logic                        ge;

    // Shared compare-and-subtract
    assign ge = (rem_reg >= dvs_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = dividend;
            dvs_next  = SUM_W'(divisor) << (scaa_pkg::QUOT_W - 1);
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            // Retire one quotient bit
            if (ge)
            begin
                rem_next = rem_reg - dvs_reg;
            end
            quot_next = {quot_reg[scaa_pkg::QUOT_W-2:0], ge};
            dvs_next  = dvs_reg >> 1;
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(scaa_pkg::QUOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

// ===== sv/subtick_calibration_averager_core.sv =====
// ----------------------------------------------------------------------------
// subtick_calibration_averager_core: subtick calibration averager
// Pairs capture timestamps into offsets, keeps them in a ring and averages
// the in-band entries with a serial walk and a serial divide.
// ----------------------------------------------------------------------------
//  Channel | Signals                                      | Direction
//  --------+----------------------------------------------+----------
//  in      | in_valid, in_stall, capture_time             | sink
//  out     | out_valid, out_stall, average_subticks,      | source
//          | latest_offset, used_fallback                 |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data    | sink
//
//  The first beat of a pair only records the start time. After the second
//  beat the core is busy before the result is offered: it writes the offset,
//  walks the ring over the single ring read port, then runs the serial
//  divider; with no entry in band the divide is skipped.
//  in_stall is high after the second beat until its result is taken.
//  rst_n clears control state and the ring valid bits at once; cfg_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module subtick_calibration_averager_core #(
    parameter int RING_DEPTH   = 16,
    parameter int OFFSET_SHIFT = 8
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             in_valid,
    output logic                            in_stall,
    input  wire [scaa_pkg::TIME_W-1:0]      capture_time,
    output logic                            out_valid,
    input  wire                             out_stall,
    output logic [scaa_pkg::OFFS_W-1:0]     average_subticks,
    output logic [scaa_pkg::OFFS_W-1:0]     latest_offset,
    output logic                            used_fallback,
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire [scaa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire [scaa_pkg::OFFS_W-1:0]      cfg_data
);

    localparam int AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW    = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = scaa_pkg::OFFS_W + CW;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WRITE = 3'd1;
    localparam logic [2:0] ST_WALK  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]                  state_reg, state_next;
    logic                        await_reg, await_next;
    logic [scaa_pkg::TIME_W-1:0] start_reg, start_next;
    logic [AW-1:0]               pos_reg, pos_next;
    logic [CW-1:0]               idx_reg, idx_next;
    logic [SUM_W-1:0]            sum_reg, sum_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    scaa_pkg::offs_t             offs_reg, offs_next;
    scaa_pkg::offs_t             avg_reg, avg_next;
    logic                        fb_reg, fb_next;
    scaa_pkg::offs_t             band_low_reg, band_high_reg, fallback_reg;

    logic [scaa_pkg::TIME_W-1:0] diff;
    scaa_pkg::offs_t             offs_calc;
    scaa_pkg::offs_t             rd_data;
    logic                        in_band;
    logic                        div_start;
    logic                        div_done;
    logic [scaa_pkg::QUOT_W-1:0] div_quot;
    logic                        in_acc;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_low_reg  <= scaa_pkg::BAND_LOW_RST;
            band_high_reg <= scaa_pkg::BAND_HIGH_RST;
            fallback_reg  <= scaa_pkg::FALLBACK_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                scaa_pkg::CFG_BAND_LOW:  band_low_reg  <= cfg_data;
                scaa_pkg::CFG_BAND_HIGH: band_high_reg <= cfg_data;
                scaa_pkg::CFG_FALLBACK:  fallback_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Offset of the second capture against the start
    assign diff      = capture_time - start_reg;
    assign offs_calc = scaa_pkg::OFFS_W'(diff >> OFFSET_SHIFT);

    assign in_band = (rd_data >= band_low_reg) && (rd_data <= band_high_reg);
    assign in_acc  = in_valid && !in_stall;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        await_next = await_reg;
        start_next = start_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        offs_next  = offs_reg;
        avg_next   = avg_reg;
        fb_next    = fb_reg;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (!await_reg)
                    begin
                        start_next = capture_time;
                        await_next = 1'b1;
                    end
                    else
                    begin
                        offs_next  = offs_calc;
                        await_next = 1'b0;
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_WRITE:
            begin
                // Store offset, advance ring position, arm the walk
                pos_next   = (pos_reg == AW'(RING_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
                idx_next   = '0;
                sum_next   = '0;
                cnt_next   = '0;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                // Registered read: read data belongs to the address of the previous cycle
                if (idx_reg != '0 && in_band)
                begin
                    sum_next = sum_reg + SUM_W'(rd_data);
                    cnt_next = cnt_reg + 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == CW'(RING_DEPTH))
                begin
                    if (cnt_next == '0)
                    begin
                        avg_next   = fallback_reg;
                        fb_next    = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (div_quot == '0)
                    begin
                        avg_next = fallback_reg;
                        fb_next  = 1'b1;
                    end
                    else
                    begin
                        avg_next = div_quot;
                        fb_next  = 1'b0;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            await_reg <= 1'b0;
            start_reg <= '0;
            pos_reg   <= '0;
            idx_reg   <= '0;
            avg_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            await_reg <= await_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
            idx_reg   <= idx_next;
            avg_reg   <= avg_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        cnt_reg  <= cnt_next;
        offs_reg <= offs_next;
        fb_reg   <= fb_next;
    end

    scaa_ring #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (state_reg == ST_WRITE),
        .wr_addr (pos_reg),
        .wr_data (offs_reg),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    scaa_divider #(
        .CNT_W (CW),
        .SUM_W (SUM_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (cnt_next),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Outputs
    assign in_stall         = (state_reg != ST_IDLE);
    assign out_valid        = (state_reg == ST_OUT);
    assign average_subticks = avg_reg;
    assign latest_offset    = offs_reg;
    assign used_fallback    = fb_reg;

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for subtick_calibration_averager_core
// Feeds capture timestamps, mostly in pairs, through the input channel with random
// gaps, stalls the result channel at random, and checks every result beat
// against an in-bench model of the offset ring and its in-band average.
// Runs several register settings, the extremes among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    localparam int RING_SLOTS  = 16;
    localparam int DRAIN_WAIT  = 40;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [scaa_pkg::OFFS_W-1:0] avg;
        logic [scaa_pkg::OFFS_W-1:0] offs;
        logic                        fb;
    } avg_result_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic [scaa_pkg::TIME_W-1:0]    capture_time;
    logic                           out_valid;
    logic                           out_stall;
    logic [scaa_pkg::OFFS_W-1:0]    average_subticks;
    logic [scaa_pkg::OFFS_W-1:0]    latest_offset;
    logic                           used_fallback;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [scaa_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [scaa_pkg::OFFS_W-1:0]    cfg_data;

    // Stimulus and expectation stores
    logic [scaa_pkg::TIME_W-1:0] stamp_queue[$];
    avg_result_t                 pending_averages[$];

    // Model state
    logic                        pair_open;
    logic [scaa_pkg::TIME_W-1:0] start_stamp;
    logic [scaa_pkg::OFFS_W-1:0] offset_ring[RING_SLOTS];
    int                          ring_idx;
    logic [scaa_pkg::OFFS_W-1:0] band_lo;
    logic [scaa_pkg::OFFS_W-1:0] band_hi;
    logic [scaa_pkg::OFFS_W-1:0] fallback_val;

    // Handshake bookkeeping
    bit  stamp_taken;
    bit  in_idle_on;
    bit  out_idle_on;
    int  in_gap;
    int  out_hold;
    int  cycle_count;
    int  err_count;

    subtick_calibration_averager_core i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .capture_time     (capture_time),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .average_subticks (average_subticks),
        .latest_offset    (latest_offset),
        .used_fallback    (used_fallback),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // Generate the clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        err_count++;
    endtask

    // Random idle length: mostly short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Advance the model by one accepted capture beat
    task automatic predict_capture(input logic [scaa_pkg::TIME_W-1:0] stamp);
        logic [scaa_pkg::TIME_W-1:0] diff;
        logic [scaa_pkg::OFFS_W-1:0] offs;
        int                          sum;
        int                          count;
        int                          quot;
        avg_result_t                 res;
        if (!pair_open)
        begin
            start_stamp = stamp;
            pair_open   = 1'b1;
        end
        else
        begin
            diff = stamp - start_stamp;
            offs = diff[scaa_pkg::TIME_W-1:scaa_pkg::OFFS_W];
            offset_ring[ring_idx] = offs;
            ring_idx = (ring_idx + 1) % RING_SLOTS;
            sum   = 0;
            count = 0;
            for (int k = 0; k < RING_SLOTS; k++)
            begin
                if (offset_ring[k] >= band_lo && offset_ring[k] <= band_hi)
                begin
                    sum += int'(offset_ring[k]);
                    count++;
                end
            end
            quot = (count != 0) ? sum / count : 0;
            // Empty band and zero quotient both fall back
            if (quot > 0)
            begin
                res.avg = quot[scaa_pkg::OFFS_W-1:0];
                res.fb  = 1'b0;
            end
            else
            begin
                res.avg = fallback_val;
                res.fb  = 1'b1;
            end
            res.offs  = offs;
            pair_open = 1'b0;
            pending_averages.push_back(res);
        end
    endtask

    // Queue one pair whose offset lands near the band most of the time
    task automatic queue_pair();
        logic [scaa_pkg::TIME_W-1:0] first;
        logic [scaa_pkg::TIME_W-1:0] delta;
        int                          lo;
        int                          hi;
        int                          offs;
        first = 16'($urandom_range(0, 65535));
        lo    = int'(band_lo);
        hi    = int'(band_hi);
        if ($urandom_range(0, 99) < 65 && lo <= hi)
        begin
            offs = $urandom_range((lo > 2) ? lo - 2 : 0, (hi < 253) ? hi + 2 : 255);
        end
        else
        begin
            offs = $urandom_range(0, 255);
        end
        delta = {offs[7:0], 8'($urandom_range(0, 255))};
        stamp_queue.push_back(first);
        stamp_queue.push_back(first + delta);
    endtask

    // Wait until every beat is in and every result is out, then settle
    task automatic wait_drained();
        while (stamp_queue.size() != 0 || in_valid || pending_averages.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    // Write all three registers back to back
    task automatic set_config(input logic [scaa_pkg::OFFS_W-1:0] lo,
                              input logic [scaa_pkg::OFFS_W-1:0] hi,
                              input logic [scaa_pkg::OFFS_W-1:0] fb);
        logic [scaa_pkg::CFG_IDX_W-1:0] idx[3];
        logic [scaa_pkg::OFFS_W-1:0]    val[3];
        idx[0] = scaa_pkg::CFG_BAND_LOW;
        idx[1] = scaa_pkg::CFG_BAND_HIGH;
        idx[2] = scaa_pkg::CFG_FALLBACK;
        val[0] = lo;
        val[1] = hi;
        val[2] = fb;
        for (int i = 0; i < 3; i++)
        begin
            @(negedge clk);
            cfg_valid = 1'b1;
            cfg_index = idx[i];
            cfg_data  = val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Drive capture beats from the queue at the falling edge
    always @(negedge clk)
    begin
        bit                          next_valid;
        logic [scaa_pkg::TIME_W-1:0] next_stamp;
        next_valid = in_valid;
        next_stamp = capture_time;
        if (stamp_taken)
        begin
            stamp_taken = 1'b0;
            next_valid  = 1'b0;
            in_gap      = in_idle_on ? gap_len() : 0;
        end
        if (!next_valid && rst_n)
        begin
            if (in_gap > 0)
                in_gap--;
            else if (stamp_queue.size() != 0)
            begin
                next_stamp = stamp_queue.pop_front();
                next_valid = 1'b1;
            end
        end
        capture_time = next_stamp;
        in_valid     = next_valid;
    end

    // Stall the result channel at random
    always @(negedge clk)
    begin
        if (out_hold > 0)
        begin
            out_hold--;
            out_stall = 1'b1;
        end
        else
        begin
            out_hold  = out_idle_on ? gap_len() : 0;
            out_stall = (out_hold > 0);
            if (out_hold > 0)
                out_hold--;
        end
    end

    // Sample beats at the rising edge and check results
    always @(posedge clk)
    begin
        avg_result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
        else if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    scaa_pkg::CFG_BAND_LOW:  band_lo      = cfg_data;
                    scaa_pkg::CFG_BAND_HIGH: band_hi      = cfg_data;
                    scaa_pkg::CFG_FALLBACK:  fallback_val = cfg_data;
                    default:                 ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                predict_capture(capture_time);
                stamp_taken = 1'b1;
            end
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (pending_averages.size() == 0)
                    report_mismatch("result beat with no expected result");
                else
                begin
                    want = pending_averages.pop_front();
                    if (average_subticks !== want.avg)
                        report_mismatch($sformatf("average_subticks %0d, expected %0d",
                                                  average_subticks, want.avg));
                    if (latest_offset !== want.offs)
                        report_mismatch($sformatf("latest_offset %0d, expected %0d",
                                                  latest_offset, want.offs));
                    if (used_fallback !== want.fb)
                        report_mismatch($sformatf("used_fallback %0b, expected %0b",
                                                  used_fallback, want.fb));
                end
            end
        end
    end

    // Reset, directed pairs, then random phases
    initial
    begin
        logic [scaa_pkg::OFFS_W-1:0] lo_tab[10];
        logic [scaa_pkg::OFFS_W-1:0] hi_tab[10];
        logic [scaa_pkg::OFFS_W-1:0] fb_tab[10];
        logic [scaa_pkg::OFFS_W-1:0] a;
        logic [scaa_pkg::OFFS_W-1:0] b;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        capture_time = '0;
        out_stall    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = scaa_pkg::CFG_BAND_LOW;
        cfg_data     = '0;
        stamp_taken  = 1'b0;
        in_idle_on   = 1'b1;
        out_idle_on  = 1'b1;
        in_gap       = 0;
        out_hold     = 0;
        cycle_count  = 0;
        err_count    = 0;
        pair_open    = 1'b0;
        start_stamp  = '0;
        ring_idx     = 0;
        band_lo      = scaa_pkg::BAND_LOW_RST;
        band_hi      = scaa_pkg::BAND_HIGH_RST;
        fallback_val = scaa_pkg::FALLBACK_RST;
        for (int k = 0; k < RING_SLOTS; k++)
            offset_ring[k] = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: band edges, zero and full offsets, timer wrap
        stamp_queue.push_back(16'h0000);
        stamp_queue.push_back(16'h8600);
        stamp_queue.push_back(16'hFFFF);
        stamp_queue.push_back(16'hA4FF);
        stamp_queue.push_back(16'h1234);
        stamp_queue.push_back(16'h1234);
        stamp_queue.push_back(16'h8000);
        stamp_queue.push_back(16'h7FFF);
        stamp_queue.push_back(16'hFFFF);
        stamp_queue.push_back(16'h0000);
        wait_drained();

        // Zero average: only zero entries lie in the band
        set_config(8'd0, 8'd0, 8'hF7);
        stamp_queue.push_back(16'h5555);
        stamp_queue.push_back(16'h55AA);
        wait_drained();

        // Empty band: low above high
        set_config(8'd200, 8'd100, 8'd0);
        stamp_queue.push_back(16'hAAAA);
        stamp_queue.push_back(16'h5555);
        wait_drained();

        // Full band, largest offsets
        set_config(8'd0, 8'd255, 8'd255);
        stamp_queue.push_back(16'h0100);
        stamp_queue.push_back(16'h0000);
        stamp_queue.push_back(16'h0000);
        stamp_queue.push_back(16'hFFFF);
        wait_drained();

        // Register settings for the random phases
        lo_tab[0] = scaa_pkg::BAND_LOW_RST;
        hi_tab[0] = scaa_pkg::BAND_HIGH_RST;
        fb_tab[0] = scaa_pkg::FALLBACK_RST;
        lo_tab[1] = 8'd0;         hi_tab[1] = 8'd255;        fb_tab[1] = 8'd0;
        lo_tab[2] = 8'd255;       hi_tab[2] = 8'd255;        fb_tab[2] = 8'd255;
        lo_tab[3] = 8'd0;         hi_tab[3] = 8'd0;          fb_tab[3] = 8'hF7;
        lo_tab[4] = 8'd200;       hi_tab[4] = 8'd100;        fb_tab[4] = 8'd17;
        for (int p = 5; p < 10; p++)
        begin
            a = 8'($urandom_range(0, 255));
            b = 8'($urandom_range(0, 255));
            // keep most random bands ordered, one may come out swapped
            if (p != 9 && a > b)
            begin
                lo_tab[p] = b;
                hi_tab[p] = a;
            end
            else
            begin
                lo_tab[p] = a;
                hi_tab[p] = b;
            end
            fb_tab[p] = 8'($urandom_range(0, 255));
        end

        for (int p = 0; p < 10; p++)
        begin
            set_config(lo_tab[p], hi_tab[p], fb_tab[p]);
            in_idle_on  = (p % 3 != 2);
            out_idle_on = (p % 3 != 2);
            for (int n = 0; n < 57; n++)
            begin
                // drop in a lone stamp now and then to shift the pairing
                if ($urandom_range(0, 99) < 4)
                    stamp_queue.push_back(16'($urandom_range(0, 65535)));
                queue_pair();
            end
            wait_drained();
        end

        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
